@@ sv/graphene_pair_hopping_macros.svh @@
// Assertion macros shared by the pair hopping RTL.
`ifndef GRAPHENE_PAIR_HOPPING_MACROS_SVH
`define GRAPHENE_PAIR_HOPPING_MACROS_SVH

// Check a property in the same cycle as its trigger.
`define GPH_ASSERT_NOW(label, trig, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (prop)) \
      else $error(msg);

// Check a property in the cycle after its trigger.
`define GPH_ASSERT_NEXT(label, trig, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (prop)) \
      else $error(msg);

`endif

@@ sv/gph_pkg.sv @@
// Types, widths and constants of the pair hopping pipeline.
`default_nettype none
package gph_pkg;

   localparam int SQRT_STEPS = 32;
   localparam int LOG_STEPS  = 16;
   localparam int EXP_STEPS  = 16;
   localparam int EXP_LAT    = EXP_STEPS + 2;
   localparam int EXP_X_W    = 25;
   localparam int EXP_M_W    = 31;
   localparam int EXP_Y_W    = 48;

   localparam logic [30:0] Q30_ONE   = 31'd1073741824;
   localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
   localparam logic [22:0] LIM_Q16   = 23'd4194304;

   typedef logic [EXP_M_W-1:0] exp_tab_type [EXP_STEPS];

   // 2^(2^-k) in Q1.30 for k = 1 .. 16
   localparam exp_tab_type EXP2_TAB = '{
      31'd1518500250, 31'd1276901417, 31'd1170923762, 31'd1121280436,
      31'd1097253708, 31'd1085434106, 31'd1079572136, 31'd1076653030,
      31'd1075196443, 31'd1074468888, 31'd1074105294, 31'd1073923544,
      31'd1073832680, 31'd1073787251, 31'd1073764537, 31'd1073753181
   };

   typedef enum logic [1:0] {
      REGION_NONE    = 2'd0,
      REGION_SITE    = 2'd1,
      REGION_INPLANE = 2'd2,
      REGION_INTER   = 2'd3
   } region_type;

   typedef enum logic [2:0] {
      CSR_SITE_ENERGY  = 3'd0,
      CSR_INPLANE_DIST = 3'd1,
      CSR_INPLANE_HOP  = 3'd2,
      CSR_INTER_DIST   = 3'd3,
      CSR_INTER_HOP    = 3'd4,
      CSR_INTER_CUTOFF = 3'd5,
      CSR_INV_DECAY_Z  = 3'd6,
      CSR_INV_DECAY_XY = 3'd7
   } csr_index_type;

   // Result decided at classification, carried to the output stage
   typedef struct packed {
      region_type  region;
      logic        overlap;
      logic [31:0] ham;
   } side_type;

endpackage
`default_nettype wire

@@ sv/gph_isqrt.sv @@
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module gph_isqrt
   import gph_pkg::*;
(
   input  logic        clock,
   input  logic        advance,
   input  logic [63:0] radicand,
   output logic [31:0] root
);

   logic [63:0] rem_ff [SQRT_STEPS-1];
   logic [63:0] r_ff   [SQRT_STEPS];

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
      logic [63:0] rem_cur;
      logic [63:0] r_cur;
      logic [64:0] trial;
      logic [63:0] rem_in;
      logic [63:0] r_in;

      if (k == 0) begin : g_first
         assign rem_cur = radicand;
         assign r_cur   = '0;
      end else begin : g_next
         assign rem_cur = rem_ff[k-1];
         assign r_cur   = r_ff[k-1];
      end

      // Try one root bit: subtract when it fits
      always_comb begin
         trial = {1'b0, r_cur} + {1'b0, BIT};
         if ({1'b0, rem_cur} >= trial) begin
            rem_in = rem_cur - trial[63:0];
            r_in   = (r_cur >> 1) + BIT;
         end else begin
            rem_in = rem_cur;
            r_in   = r_cur >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            r_ff[k] <= r_in;
         end
      end

      if (k < SQRT_STEPS - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (advance) begin
               rem_ff[k] <= rem_in;
            end
         end
      end
   end

   assign root = r_ff[SQRT_STEPS-1][31:0];

endmodule
`default_nettype wire

@@ sv/gph_exp2.sv @@
// Pipelined fixed-point 2^x, signed Q9.16 in and Q32.16 out, one fraction bit per stage.
`default_nettype none
module gph_exp2
   import gph_pkg::*;
(
   input  logic                      clock,
   input  logic                      advance,
   input  logic signed [EXP_X_W-1:0] x,
   output logic [EXP_Y_W-1:0]        y
);

   localparam logic signed [EXP_X_W-1:0] X_MIN = EXP_X_W'(-1114112);
   localparam logic signed [EXP_X_W-1:0] X_MAX = EXP_X_W'(2031616);
   localparam logic [EXP_Y_W-1:0]        Y_MAX = EXP_Y_W'(1) << 47;

   logic               zero_ff [EXP_STEPS+1];
   logic               max_ff  [EXP_STEPS+1];
   logic [5:0]         sh_ff   [EXP_STEPS+1];
   logic [15:0]        f_ff    [EXP_STEPS+1];
   logic [EXP_M_W-1:0] m_ff    [EXP_STEPS+1];
   logic [EXP_M_W-1:0] m_in    [EXP_STEPS];
   logic [EXP_Y_W-1:0] y_ff;
   logic signed [9:0]  sh_full;

   // Shift that turns the Q1.30 mantissa into the Q32.16 result: 30 minus integer part
   assign sh_full = 10'sd30 - 10'(x >>> 16);

   // Multiply in one table factor per set fraction bit
   always_comb begin
      logic [61:0] prod;
      for (int k = 0; k < EXP_STEPS; k++) begin
         prod = 62'(m_ff[k]) * 62'(EXP2_TAB[k]);
         m_in[k] = f_ff[k][4'(EXP_STEPS - 1 - k)] ? prod[60:30] : m_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         zero_ff[0] <= x < X_MIN;
         max_ff[0]  <= x >= X_MAX;
         sh_ff[0]   <= sh_full[5:0];
         f_ff[0]    <= x[15:0];
         m_ff[0]    <= Q30_ONE;
         for (int k = 1; k <= EXP_STEPS; k++) begin
            zero_ff[k] <= zero_ff[k-1];
            max_ff[k]  <= max_ff[k-1];
            sh_ff[k]   <= sh_ff[k-1];
            f_ff[k]    <= f_ff[k-1];
            m_ff[k]    <= m_in[k-1];
         end
         if (zero_ff[EXP_STEPS]) begin
            y_ff <= '0;
         end else if (max_ff[EXP_STEPS]) begin
            y_ff <= Y_MAX;
         end else begin
            y_ff <= EXP_Y_W'({m_ff[EXP_STEPS], 16'b0} >> sh_ff[EXP_STEPS]);
         end
      end
   end

   assign y = y_ff;

endmodule
`default_nettype wire

@@ sv/graphene_pair_hopping.sv @@
// Top level: tight-binding Hamiltonian and overlap element for one atom pair.
//
// req_ channel takes one atom pair per word: six Q16.16 coordinates in
// tdata, the two carbon flags in tuser. rsp_ channel returns one word per
// pair: the Hamiltonian element in tdata, overlap and region code in tuser.
// csr_ port writes the eight hopping registers, one per cycle, with no
// read-back; write only while no pair is in flight.
// A new pair is taken every cycle while rsp_ does not stall. The depth is
// set by two 32-step square roots, a 16-step log2 by squaring and two
// 16-step exp2 units, each step one stage.
// The whole pipeline moves as one: while rsp_tvalid is high and rsp_tready
// is low every stage holds and req_tready is low; otherwise it advances.
// Reset clears the valid bits of all stages and loads the register defaults.
`default_nettype none
`include "graphene_pair_hopping_macros.svh"
module graphene_pair_hopping
   import gph_pkg::*;
#(
   parameter int DIST_TOL_Q16 = 6554,
   parameter int ALPHA_Q8     = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // atom_i_x, atom_i_y, atom_i_z, atom_j_x, atom_j_y, atom_j_z
   input  logic [191:0] req_tdata,
   // atom_i_carbon, atom_j_carbon
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // ham_element
   output logic [31:0]  rsp_tdata,
   // overlap_element, pair_region
   output logic [2:0]   rsp_tuser,
   input  logic         csr_wen,
   input  logic [2:0]   csr_addr,
   input  logic [31:0]  csr_wdata
);

   localparam int LAT      = 4 + SQRT_STEPS + 4 + LOG_STEPS + 2 + EXP_LAT + 3 + EXP_LAT + 2;
   localparam int AZ_DLY   = SQRT_STEPS;
   localparam int SIDE_DLY = 3 + LOG_STEPS + 2 + EXP_LAT + 3 + EXP_LAT + 1;
   localparam int ZT_DLY   = 1 + LOG_STEPS + 2 + EXP_LAT;
   localparam int B_DLY    = 1 + LOG_STEPS;
   localparam logic [32:0] TOL = 33'(DIST_TOL_Q16);
   localparam logic [31:0] MAG_MAX = 32'h8000_0000;

   function automatic logic [31:0] abs_diff32(logic [31:0] a, logic [31:0] b);
      logic signed [32:0] d;
      d = $signed({a[31], a}) - $signed({b[31], b});
      return d[32] ? 32'(-d) : d[31:0];
   endfunction

   function automatic logic [32:0] abs_diff_u(logic [31:0] a, logic [31:0] b);
      logic signed [33:0] d;
      d = $signed({2'b0, a}) - $signed({2'b0, b});
      return d[33] ? 33'(-d) : d[32:0];
   endfunction

   // Configuration registers
   logic [31:0] site_energy_ff;
   logic [30:0] ip_dist_ff, ip_hop_ff, il_dist_ff, il_hop_ff, il_cut_ff, inv_z_ff, inv_xy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         site_energy_ff <= '0;
         ip_dist_ff     <= 31'd93061;
         ip_hop_ff      <= 31'd183501;
         il_dist_ff     <= 31'd219546;
         il_hop_ff      <= 31'd26214;
         il_cut_ff      <= '0;
         inv_z_ff       <= 31'd65536;
         inv_xy_ff      <= 31'd65536;
      end else if (csr_wen) begin
         unique case (csr_index_type'(csr_addr))
            CSR_SITE_ENERGY:  site_energy_ff <= csr_wdata;
            CSR_INPLANE_DIST: ip_dist_ff     <= csr_wdata[30:0];
            CSR_INPLANE_HOP:  ip_hop_ff      <= csr_wdata[30:0];
            CSR_INTER_DIST:   il_dist_ff     <= csr_wdata[30:0];
            CSR_INTER_HOP:    il_hop_ff      <= csr_wdata[30:0];
            CSR_INTER_CUTOFF: il_cut_ff      <= csr_wdata[30:0];
            CSR_INV_DECAY_Z:  inv_z_ff       <= csr_wdata[30:0];
            CSR_INV_DECAY_XY: inv_xy_ff      <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   // Global advance and valid bits
   logic           adv;
   logic [LAT-1:0] vld_ff;

   assign adv        = !vld_ff[LAT-1] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAT-2:0], req_tvalid};
      end
   end

   // Front end: differences, squares, saturating sums
   logic [31:0] ax_ff, ay_ff, az1_ff, az2_ff, az3_ff;
   logic        carb1_ff, carb2_ff, carb3_ff;
   logic [63:0] sqx_ff, sqy_ff, sqz_ff, sqz3_ff, sxy3_ff, sxy4_ff, sall_ff;
   logic [64:0] sum_xy, sum_all;

   assign sum_xy  = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign sum_all = {1'b0, sxy3_ff} + {1'b0, sqz3_ff};

   always_ff @(posedge clock) begin
      if (adv) begin
         ax_ff    <= abs_diff32(req_tdata[31:0], req_tdata[127:96]);
         ay_ff    <= abs_diff32(req_tdata[63:32], req_tdata[159:128]);
         az1_ff   <= abs_diff32(req_tdata[95:64], req_tdata[191:160]);
         carb1_ff <= req_tuser[0] && req_tuser[1];
         sqx_ff   <= 64'(ax_ff) * 64'(ax_ff);
         sqy_ff   <= 64'(ay_ff) * 64'(ay_ff);
         sqz_ff   <= 64'(az1_ff) * 64'(az1_ff);
         az2_ff   <= az1_ff;
         carb2_ff <= carb1_ff;
         sxy3_ff  <= sum_xy[64] ? '1 : sum_xy[63:0];
         sqz3_ff  <= sqz_ff;
         az3_ff   <= az2_ff;
         carb3_ff <= carb2_ff;
         sall_ff  <= sum_all[64] ? '1 : sum_all[63:0];
         sxy4_ff  <= sxy3_ff;
      end
   end

   // Distances
   logic [31:0] d_w, dxy_w;

   gph_isqrt u_sqrt_d (
      .clock(clock), .advance(adv), .radicand(sall_ff), .root(d_w)
   );

   gph_isqrt u_sqrt_xy (
      .clock(clock), .advance(adv), .radicand(sxy4_ff), .root(dxy_w)
   );

   logic [31:0] az_dl_ff   [AZ_DLY+1];
   logic        carb_dl_ff [AZ_DLY+1];

   always_ff @(posedge clock) begin
      if (adv) begin
         az_dl_ff[0]   <= az3_ff;
         carb_dl_ff[0] <= carb3_ff;
         for (int k = 1; k <= AZ_DLY; k++) begin
            az_dl_ff[k]   <= az_dl_ff[k-1];
            carb_dl_ff[k] <= carb_dl_ff[k-1];
         end
      end
   end

   // Classify the pair
   logic [31:0] az_c;
   logic        is_site, is_inpl, is_inter;
   logic [32:0] exc_mag;
   logic        exc_neg;
   side_type    side_in;

   assign az_c     = az_dl_ff[AZ_DLY];
   assign is_site  = {1'b0, d_w} <= TOL;
   assign is_inpl  = ({1'b0, az_c} <= TOL) && (abs_diff_u(d_w, {1'b0, ip_dist_ff}) <= TOL);
   assign exc_mag  = abs_diff_u(d_w, {1'b0, il_dist_ff});
   assign exc_neg  = d_w < {1'b0, il_dist_ff};
   assign is_inter = (abs_diff_u(az_c, {1'b0, il_dist_ff}) <= TOL)
                     && (exc_mag <= {2'b0, il_cut_ff} + TOL);

   always_comb begin
      side_in = '{region: REGION_NONE, overlap: 1'b0, ham: '0};
      if (carb_dl_ff[AZ_DLY]) begin
         if (is_site) begin
            side_in = '{region: REGION_SITE, overlap: 1'b1, ham: site_energy_ff};
         end else if (is_inpl) begin
            side_in = '{region: REGION_INPLANE, overlap: 1'b0,
                        ham: 32'(-{1'b0, ip_hop_ff})};
         end else if (is_inter) begin
            side_in = '{region: REGION_INTER, overlap: 1'b0, ham: '0};
         end
      end
   end

   side_type    side_dl_ff [SIDE_DLY+1];
   logic [31:0] mexc_ff, dxy_ff;
   logic        neg1_ff, neg2_ff;
   logic [62:0] prodz_ff, produ_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         side_dl_ff[0] <= side_in;
         for (int k = 1; k <= SIDE_DLY; k++) begin
            side_dl_ff[k] <= side_dl_ff[k-1];
         end
         mexc_ff  <= exc_mag[31:0];
         neg1_ff  <= exc_neg;
         dxy_ff   <= dxy_w;
         prodz_ff <= 63'(64'(mexc_ff) * 64'(inv_z_ff));
         produ_ff <= 63'(64'(dxy_ff) * 64'(inv_xy_ff));
         neg2_ff  <= neg1_ff;
      end
   end

   // Vertical term, lateral argument and its leading one
   logic [46:0]       zm, u_w;
   logic [22:0]       zmc;
   logic [5:0]        b_w;
   logic signed [23:0] zt_dl_ff [ZT_DLY+1];
   logic              uz_dl_ff [ZT_DLY+1];
   logic [5:0]        b_dl_ff  [B_DLY+1];
   logic [46:0]       u_ff;

   assign zm  = prodz_ff[62:16];
   assign u_w = produ_ff[62:16];
   assign zmc = (zm > 47'(LIM_Q16)) ? LIM_Q16 : zm[22:0];

   always_comb begin
      b_w = '0;
      for (int i = 0; i < 47; i++) begin
         if (u_w[i]) begin
            b_w = 6'(i);
         end
      end
   end

   // Log2 by repeated squaring
   logic [30:0] lm_ff [LOG_STEPS];
   logic [15:0] lf_ff [LOG_STEPS+1];
   logic [30:0] lm_in [LOG_STEPS];
   logic [15:0] lf_in [LOG_STEPS];

   always_comb begin
      logic [61:0] sq;
      for (int k = 0; k < LOG_STEPS; k++) begin
         sq = 62'(lm_ff[k]) * 62'(lm_ff[k]);
         if (sq[61]) begin
            lm_in[k] = sq[61:31];
            lf_in[k] = {lf_ff[k][14:0], 1'b1};
         end else begin
            lm_in[k] = sq[60:30];
            lf_in[k] = {lf_ff[k][14:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         zt_dl_ff[0] <= neg2_ff ? -$signed({1'b0, zmc}) : $signed({1'b0, zmc});
         uz_dl_ff[0] <= u_w == '0;
         b_dl_ff[0]  <= b_w;
         u_ff        <= u_w;
         for (int k = 1; k <= ZT_DLY; k++) begin
            zt_dl_ff[k] <= zt_dl_ff[k-1];
            uz_dl_ff[k] <= uz_dl_ff[k-1];
         end
         for (int k = 1; k <= B_DLY; k++) begin
            b_dl_ff[k] <= b_dl_ff[k-1];
         end
         lm_ff[0] <= 31'({u_ff, 30'b0} >> b_dl_ff[0]);
         lf_ff[0] <= '0;
         for (int k = 1; k < LOG_STEPS; k++) begin
            lm_ff[k] <= lm_in[k-1];
         end
         for (int k = 1; k <= LOG_STEPS; k++) begin
            lf_ff[k] <= lf_in[k-1];
         end
      end
   end

   // Scale log2 by alpha
   logic signed [6:0]       lg_int;
   logic signed [22:0]      lg;
   logic [22:0]             lg_mag;
   logic [39:0]             alpha_prod;
   logic [EXP_X_W-2:0]      pm_ff;
   logic                    pneg_ff;
   logic signed [EXP_X_W-1:0] p_ff;

   assign lg_int     = $signed({1'b0, b_dl_ff[B_DLY]}) - 7'sd16;
   assign lg         = {lg_int, lf_ff[LOG_STEPS]};
   assign lg_mag     = lg[22] ? 23'(-lg) : lg;
   assign alpha_prod = 40'(lg_mag) * 40'(ALPHA_Q8);

   always_ff @(posedge clock) begin
      if (adv) begin
         pm_ff   <= alpha_prod[EXP_X_W+6:8];
         pneg_ff <= lg[22];
         p_ff    <= pneg_ff ? -$signed({1'b0, pm_ff}) : $signed({1'b0, pm_ff});
      end
   end

   logic [EXP_Y_W-1:0] e_w;

   gph_exp2 u_exp_pow (
      .clock(clock), .advance(adv), .x(p_ff), .y(e_w)
   );

   // Exponent sum, times log2(e)
   logic [22:0]        pw;
   logic signed [25:0] s_raw;
   logic signed [23:0] s_ff;
   logic [53:0]        xprod_ff;
   logic               sneg_ff;
   logic [22:0]        s_mag;
   logic signed [EXP_X_W-1:0] x_ff;

   assign pw    = uz_dl_ff[ZT_DLY] ? '0 :
                  ((e_w > EXP_Y_W'(LIM_Q16)) ? LIM_Q16 : e_w[22:0]);
   assign s_raw = -26'(zt_dl_ff[ZT_DLY]) - $signed({3'b0, pw});
   assign s_mag = s_ff[23] ? 23'(-s_ff) : s_ff[22:0];

   always_ff @(posedge clock) begin
      if (adv) begin
         if (s_raw > $signed({3'b0, LIM_Q16})) begin
            s_ff <= $signed({1'b0, LIM_Q16});
         end else if (s_raw < -$signed({3'b0, LIM_Q16})) begin
            s_ff <= -$signed({1'b0, LIM_Q16});
         end else begin
            s_ff <= s_raw[23:0];
         end
         xprod_ff <= 54'(s_mag) * 54'(LOG2E_Q30);
         sneg_ff  <= s_ff[23];
         x_ff     <= sneg_ff ? -$signed({1'b0, xprod_ff[53:30]})
                             : $signed({1'b0, xprod_ff[53:30]});
      end
   end

   logic [EXP_Y_W-1:0] factor_w;

   gph_exp2 u_exp_fac (
      .clock(clock), .advance(adv), .x(x_ff), .y(factor_w)
   );

   // Scale the interlayer hopping and saturate
   logic [62:0] hprod_ff;
   logic        fzero_ff, big_ff;
   logic [31:0] mag_w;
   side_type    side_o;
   logic [31:0] rsp_ham_ff;
   logic        rsp_ovl_ff;
   region_type  rsp_region_ff;

   assign side_o = side_dl_ff[SIDE_DLY];

   always_comb begin
      if (fzero_ff) begin
         mag_w = '0;
      end else if (big_ff || (hprod_ff[62:16] > 47'(MAG_MAX))) begin
         mag_w = MAG_MAX;
      end else begin
         mag_w = hprod_ff[47:16];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hprod_ff      <= 63'(64'(il_hop_ff) * 64'(factor_w[31:0]));
         fzero_ff      <= (il_hop_ff == '0) || (factor_w == '0);
         big_ff        <= factor_w[47:32] != '0;
         rsp_ham_ff    <= (side_o.region == REGION_INTER) ? -mag_w : side_o.ham;
         rsp_ovl_ff    <= side_o.overlap;
         rsp_region_ff <= side_o.region;
      end
   end

   assign rsp_tdata = rsp_ham_ff;
   assign rsp_tuser = {rsp_region_ff, rsp_ovl_ff};

   // Checks
   `GPH_ASSERT_NOW(a_ovl_site, rsp_tvalid && rsp_ovl_ff, rsp_region_ff == REGION_SITE, "overlap outside same site")
   `GPH_ASSERT_NOW(a_none_zero, rsp_tvalid && rsp_region_ff == REGION_NONE, rsp_ham_ff == '0, "nonzero element with no region")
   `GPH_ASSERT_NEXT(a_stall_hold, !adv, $stable(vld_ff), "pipeline moved during stall")

endmodule
`default_nettype wire
